@@ hw/rtl/dsx_pkg.sv @@
// Package for the diagonal span extractor: coordinate widths, point and span
// types, and the operation codes carried on the input side-band.
// No dependencies.
package dsx_pkg;

    // Coordinates are 11 bits wide and wrap modulo the image size.
    localparam int COORD_W    = 11;
    localparam int IMAGE_SIZE = 1 << COORD_W;
    localparam int VALUE_W    = 8;

    // Threshold value after reset.
    localparam logic [VALUE_W-1:0] THRESHOLD_RESET = 8'd128;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t y;
        coord_t x;
    } point_t;

    // One stored span: a is the opening point, b the closing point.
    typedef struct packed {
        point_t b;
        point_t a;
    } span_t;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_PIXEL     = 2'd0,
        OP_PIXEL_END = 2'd1,
        OP_LINE_END  = 2'd2
    } op_t;

endpackage

@@ hw/rtl/dsx_span_ram.sv @@
// Span store of the diagonal span extractor: a simple dual-port memory with
// one write port and one registered read port.
// Depends on dsx_pkg for the span type.
module dsx_span_ram
    import dsx_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  span_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output span_t         rd_data
);

    span_t mem [DEPTH];
    span_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/diagonal_span_extractor_unit.sv @@
// Top level of the diagonal span extractor: pixel classification, span
// capture into the span store and the line-end emission sequencer.
// Depends on dsx_pkg and dsx_span_ram.
//
// Usage:
// Pixels of one diagonal scan line enter on the s_ channel, one item each,
// with the operation code on s_tuser. Pixels are taken one per cycle; a
// pixel that crosses the threshold opens or closes a span, and closed spans
// are written into the span store (MAX_SPANS entries, extra spans dropped).
// An item that ends a line starts the emission: s_tready drops while the
// stored spans are read back and sent on the m_ channel, in order on even
// lines and reversed with swapped endpoints on odd lines, where zero-length
// spans are skipped. m_tlast marks the final stroke of a line.
// Emission steps through ST_READ for the first store read, ST_CHECK once per
// span through the read port, and ST_FLUSH to send the held stroke. A line
// with no stored span goes straight to ST_FLUSH.
// The output register is held while m_tready is low; the emission then
// waits on that register. Reset clears all control state, restores the
// threshold to 128 and starts on an even line; the store needs no clearing.
module diagonal_span_extractor_unit
    import dsx_pkg::*;
#(
    parameter int MAX_SPANS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    // Threshold register write.
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    // Input items.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // pixel_x[10:0], pixel_y[21:11], pixel_value[29:22]
    input  logic [1:0]   s_tuser,   // operation[1:0]
    // Result items.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // start_x[10:0], start_y[21:11], end_x[32:22], end_y[43:33]
    output logic         m_tlast    // last_stroke
);

    localparam int AW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
    localparam int CW = $clog2(MAX_SPANS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FLUSH
    } state_t;

    // Control registers.
    state_t              state_reg, state_next;
    logic [VALUE_W-1:0]  threshold_reg;
    logic                outside_reg, outside_next;
    logic                reverse_reg, reverse_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                m_valid_reg, m_valid_next;

    // Payload registers.
    point_t              open_reg;
    point_t              last_reg;
    span_t               pend_reg, pend_next;
    span_t               m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    // Input fields.
    op_t                 op;
    point_t              pix;
    logic [VALUE_W-1:0]  pix_value;
    logic                accept;

    // Pixel classification.
    logic                is_pix, is_end;
    logic                pix_close, pix_open, end_close;
    logic                outside_after_pix;
    point_t              open_cur, last_cur, close_pt;
    logic                wr_en;
    span_t               wr_data;

    // Emission.
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    span_t               rd_data;
    span_t               cand;
    logic                keep, out_free, at_last_idx;

    assign op        = op_t'(s_tuser);
    assign pix.x     = s_tdata[COORD_W-1:0];
    assign pix.y     = s_tdata[2*COORD_W-1:COORD_W];
    assign pix_value = s_tdata[2*COORD_W+VALUE_W-1:2*COORD_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    // Threshold crossings of the incoming pixel and the line-end close.
    always_comb
    begin
        is_pix            = (op inside {OP_PIXEL, OP_PIXEL_END});
        is_end            = (op inside {OP_PIXEL_END, OP_LINE_END});
        pix_close         = is_pix && (pix_value > threshold_reg) && !outside_reg;
        pix_open          = is_pix && (pix_value < threshold_reg) && outside_reg;
        open_cur          = pix_open ? pix : open_reg;
        last_cur          = is_pix ? pix : last_reg;
        outside_after_pix = pix_close ? 1'b1 : (pix_open ? 1'b0 : outside_reg);
        end_close         = is_end && !outside_after_pix;
        if (pix_close)
        begin
            close_pt.x = pix.x - coord_t'(1);
            close_pt.y = pix.y + coord_t'(1);
        end
        else
        begin
            close_pt.x = last_cur.x + coord_t'(1);
            close_pt.y = last_cur.y - coord_t'(1);
        end
        wr_data.a = open_cur;
        wr_data.b = close_pt;
        wr_en     = accept && (pix_close || end_close) && (count_reg < CW'(MAX_SPANS));
    end

    // Candidate stroke from the store read, oriented for the line direction.
    always_comb
    begin
        if (reverse_reg)
        begin
            cand.a = rd_data.b;
            cand.b = rd_data.a;
            keep   = (rd_data.a != rd_data.b);
        end
        else
        begin
            cand = rd_data;
            keep = 1'b1;
        end
        out_free = !m_valid_reg || m_tready;
        if (reverse_reg)
        begin
            at_last_idx = (idx_reg == '0);
        end
        else
        begin
            at_last_idx = (CW'(idx_reg) == (count_reg - CW'(1)));
        end
    end

    // Sequencer and output register next state.
    always_comb
    begin
        state_next      = state_reg;
        outside_next    = outside_reg;
        reverse_next    = reverse_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op inside {OP_PIXEL, OP_PIXEL_END, OP_LINE_END}))
                begin
                    count_next   = count_reg + CW'(wr_en);
                    outside_next = is_end ? 1'b1 : outside_after_pix;
                    if (is_end)
                    begin
                        if (count_next == '0)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            state_next = ST_READ;
                            idx_next   = reverse_reg ? AW'(count_next - CW'(1)) : '0;
                        end
                    end
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!(keep && pend_valid_reg && !out_free))
                begin
                    if (keep)
                    begin
                        pend_next       = cand;
                        pend_valid_next = 1'b1;
                        if (pend_valid_reg)
                        begin
                            m_valid_next = 1'b1;
                            m_data_next  = pend_reg;
                            m_last_next  = 1'b0;
                        end
                    end
                    if (at_last_idx)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = reverse_reg ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
                        rd_en    = 1'b1;
                        rd_addr  = idx_next;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        m_valid_next = 1'b1;
                        m_data_next  = pend_reg;
                        m_last_next  = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    reverse_next    = !reverse_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            threshold_reg  <= THRESHOLD_RESET;
            outside_reg    <= 1'b1;
            reverse_reg    <= 1'b0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            outside_reg    <= outside_next;
            reverse_reg    <= reverse_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            open_reg <= open_cur;
            last_reg <= last_cur;
        end
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    dsx_span_ram #(
        .DEPTH (MAX_SPANS),
        .AW    (AW)
    ) u_span_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(count_reg)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output channel.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_data_reg.b.y, m_data_reg.b.x, m_data_reg.a.y, m_data_reg.a.x};
    assign m_tlast  = m_last_reg;

endmodule

@@ tb/diagonal_span_extractor_unit_test.sv @@
// Self-checking testbench for diagonal_span_extractor_unit: a directed table of
// scan-line pixels, then random threshold phases with random lines.
// Depends on dsx_pkg and the extractor RTL only.
`timescale 1ns / 1ps

module diagonal_span_extractor_unit_test
    import dsx_pkg::*;
();

    localparam int MAX_SPANS   = 32;
    localparam int IDLE_CYCLES = MAX_SPANS + 16;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 32;
    localparam int DENSE_LEN   = 68;
    localparam int MAX_REPORTS = 10;

    // Operation code with no meaning to the block; it must be dropped.
    localparam logic [1:0] OP_IGNORED = 2'd3;

    // One stroke on the output side.
    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        logic   is_last;
    } stroke_t;

    // One row of the directed table; typed rows carry their single stroke.
    typedef struct packed {
        logic [1:0]   op;
        coord_t       x;
        coord_t       y;
        logic [7:0]   v;
        logic         typed;
        stroke_t      result;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [7:0]   cfg_wr_data = 8'd0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = 32'd0;
    logic [1:0]   s_tuser = 2'd0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;
    logic         m_tlast;

    // Side information that travels with each item in the directed part.
    logic         row_typed = 1'b0;
    stroke_t      row_stroke = '0;

    // Predictor state.
    logic [7:0]   level_model = THRESHOLD_RESET;
    logic         inside_span = 1'b0;
    logic         odd_line = 1'b0;
    point_t       span_origin;
    point_t       prev_pixel;
    span_t        span_bank [MAX_SPANS];
    int           span_total = 0;
    stroke_t      expected_strokes [$];

    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           items_sent = 0;
    int           burst_left = 0;
    int           hold_requests = 0;
    int           hold_served = 0;
    int           hold_left = 0;
    int           rx_cycle = 0;

    stim_row_t    directed_rows [17];
    logic [7:0]   phase_levels [6];

    diagonal_span_extractor_unit #(.MAX_SPANS(MAX_SPANS)) DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always #5 clk = ~clk;

    // Store a closed span if there is room; the span is closed either way.
    task automatic bank_span(input point_t close_pt);
        if (span_total < MAX_SPANS)
        begin
            span_bank[span_total].a = span_origin;
            span_bank[span_total].b = close_pt;
            span_total++;
        end
        inside_span = 1'b0;
    endtask

    // Line end: close any open span, then queue the strokes of the line.
    task automatic close_line();
        point_t  tail_pt;
        stroke_t line_strokes [$];
        stroke_t entry;
        int      i;
        if (inside_span)
        begin
            tail_pt.x = prev_pixel.x + 1'b1;
            tail_pt.y = prev_pixel.y - 1'b1;
            bank_span(tail_pt);
        end
        if (!odd_line)
        begin
            for (i = 0; i < span_total; i++)
            begin
                entry = '{span_bank[i].a.x, span_bank[i].a.y,
                          span_bank[i].b.x, span_bank[i].b.y, 1'b0};
                line_strokes = {line_strokes, entry};
            end
        end
        else
        begin
            for (i = span_total - 1; i >= 0; i--)
                if (span_bank[i].a != span_bank[i].b)
                begin
                    entry = '{span_bank[i].b.x, span_bank[i].b.y,
                              span_bank[i].a.x, span_bank[i].a.y, 1'b0};
                    line_strokes = {line_strokes, entry};
                end
        end
        if (line_strokes.size() != 0)
            line_strokes[line_strokes.size() - 1].is_last = 1'b1;
        expected_strokes = {expected_strokes, line_strokes};
        span_total = 0;
        inside_span = 1'b0;
        odd_line = !odd_line;
    endtask

    // Work out the strokes that one accepted item causes.
    task automatic predict_item(input logic [1:0] op, input coord_t px, input coord_t py,
                                input logic [7:0] val);
        point_t pix;
        point_t close_pt;
        if (op == OP_IGNORED)
            return;
        if (op != OP_LINE_END)
        begin
            pix.x = px;
            pix.y = py;
            if (val > level_model && inside_span)
            begin
                close_pt.x = px - 1'b1;
                close_pt.y = py + 1'b1;
                bank_span(close_pt);
            end
            else if (val < level_model && !inside_span)
            begin
                span_origin = pix;
                inside_span = 1'b1;
            end
            prev_pixel = pix;
            if (op == OP_PIXEL)
                return;
        end
        close_line();
    endtask

    task automatic note_error(input string what, input stroke_t want, input stroke_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s: want (%0d,%0d)->(%0d,%0d) last %0b, got (%0d,%0d)->(%0d,%0d) last %0b",
                     what, want.sx, want.sy, want.ex, want.ey, want.is_last,
                     got.sx, got.sy, got.ex, got.ey, got.is_last);
    endtask

    // Monitor: follows threshold writes, checks strokes, predicts from items.
    always @(posedge clk)
    begin : monitor
        stroke_t got;
        stroke_t want;
        int      depth_at_accept;
        if (rst_n)
        begin
            if (cfg_wr_en)
                level_model = cfg_wr_data;
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[10:0], m_tdata[21:11], m_tdata[32:22], m_tdata[43:33], m_tlast};
                if (expected_strokes.size() == 0)
                    note_error("unexpected stroke", '0, got);
                else
                begin
                    want = expected_strokes.pop_front();
                    if (got.sx !== want.sx || got.sy !== want.sy || got.ex !== want.ex ||
                        got.ey !== want.ey || got.is_last !== want.is_last)
                        note_error("stroke mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready)
            begin
                depth_at_accept = expected_strokes.size();
                predict_item(s_tuser, s_tdata[10:0], s_tdata[21:11], s_tdata[29:22]);
                // Typed rows replace the predicted stroke with the one from the table.
                if (row_typed)
                begin
                    while (expected_strokes.size() > depth_at_accept)
                        void'(expected_strokes.pop_back());
                    expected_strokes = {expected_strokes, row_stroke};
                end
            end
        end
    end

    // Receiver: a rotating stall pattern, with a long hold-off on request.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            m_tready <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left <= LONG_HOLD;
        end
        else
        begin
            case (rx_cycle[7:6])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= 1'($urandom_range(0, 1));
                2'd2: m_tready <= (rx_cycle[1:0] == 2'd0);
                default: m_tready <= ($urandom_range(0, 5) != 0);
            endcase
        end
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one item and wait for it to be taken; the sender idles in bursts.
    task automatic drive_item(input logic [1:0] op, input coord_t px, input coord_t py,
                              input logic [7:0] val, input logic typed, input stroke_t result);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, val, py, px};
        s_tuser <= op;
        row_typed <= typed;
        row_stroke <= result;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Wait until every stroke has come and the block has finished its line end.
    // The first edge lets the monitor queue the strokes of the last item.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_strokes.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] level);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= level;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] level_below();
        return (level_model == 8'd0) ? 8'd0 : 8'($urandom_range(0, level_model - 1));
    endfunction

    function automatic logic [7:0] level_above();
        return (level_model == 8'd255) ? 8'd255 : 8'($urandom_range(level_model + 1, 255));
    endfunction

    // Mostly values that cross the threshold, some at it, some anywhere.
    function automatic logic [7:0] pick_level();
        int r;
        r = $urandom_range(0, 19);
        if (r < 7)
            return level_below();
        else if (r < 14)
            return level_above();
        else if (r < 16)
            return level_model;
        return 8'($urandom_range(0, 255));
    endfunction

    // One diagonal line of random pixels, ended by its last pixel or by a
    // separate line end. Dense lines alternate below and above to fill the store.
    task automatic run_line(input int len, input bit dense, input bit hold_at_end);
        coord_t     x;
        coord_t     y;
        logic [7:0] val;
        logic [1:0] op;
        bit         tail_end;
        int         i;
        x = coord_t'($urandom);
        y = coord_t'($urandom);
        tail_end = (len == 0) || ($urandom_range(0, 3) == 0);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                drive_item(OP_IGNORED, coord_t'($urandom), coord_t'($urandom),
                           8'($urandom), 1'b0, '0);
            // A jump off the diagonal now and then.
            if (!dense && $urandom_range(0, 9) == 0)
            begin
                x = coord_t'($urandom);
                y = coord_t'($urandom);
            end
            val = dense ? (i[0] ? level_above() : level_below()) : pick_level();
            op = (i == len - 1 && !tail_end) ? OP_PIXEL_END : OP_PIXEL;
            if (hold_at_end && op == OP_PIXEL_END)
                hold_requests <= hold_requests + 1;
            drive_item(op, x, y, val, 1'b0, '0);
            items_sent++;
            x = x + 1'b1;
            y = y - 1'b1;
        end
        if (tail_end)
        begin
            if (hold_at_end)
                hold_requests <= hold_requests + 1;
            drive_item(OP_LINE_END, coord_t'($urandom), coord_t'($urandom),
                       8'($urandom), 1'b0, '0);
            items_sent++;
        end
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        else if (r < 8)
            return $urandom_range(1, 8);
        return $urandom_range(9, 24);
    endfunction

    initial
    begin : main
        int p;
        int phase_start;
        // Threshold 128 after reset; the first line is even.
        directed_rows = '{
            '{OP_PIXEL,     11'd0,    11'd0,    8'd0,   1'b0, '0},
            '{OP_PIXEL_END, 11'd2047, 11'd2047, 8'd255, 1'b1,
              '{11'd0, 11'd0, 11'd2046, 11'd0, 1'b1}},
            '{OP_PIXEL,     11'd0,    11'd5,    8'd127, 1'b0, '0},
            '{OP_PIXEL,     11'd1,    11'd4,    8'd128, 1'b0, '0},
            '{OP_LINE_END,  11'd0,    11'd0,    8'd0,   1'b1,
              '{11'd2, 11'd3, 11'd0, 11'd5, 1'b1}},
            '{OP_LINE_END,  11'd0,    11'd0,    8'd0,   1'b0, '0},
            '{OP_PIXEL,     11'd10,   11'd10,   8'd0,   1'b0, '0},
            '{OP_PIXEL,     11'd11,   11'd9,    8'd200, 1'b0, '0},
            '{OP_PIXEL_END, 11'd12,   11'd8,    8'd128, 1'b0, '0},
            '{OP_IGNORED,   11'd2047, 11'd2047, 8'd255, 1'b0, '0},
            '{OP_PIXEL_END, 11'd0,    11'd0,    8'd0,   1'b1,
              '{11'd0, 11'd0, 11'd1, 11'd2047, 1'b1}},
            '{OP_PIXEL,     11'd2047, 11'd0,    8'd255, 1'b0, '0},
            '{OP_PIXEL,     11'd5,    11'd5,    8'd1,   1'b0, '0},
            '{OP_PIXEL,     11'd8,    11'd1,    8'd255, 1'b0, '0},
            '{OP_PIXEL,     11'd9,    11'd0,    8'd0,   1'b0, '0},
            '{OP_LINE_END,  11'd0,    11'd0,    8'd0,   1'b0, '0},
            '{OP_PIXEL_END, 11'd100,  11'd100,  8'd128, 1'b0, '0}
        };
        phase_levels = '{8'd0, 8'd255, 8'($urandom_range(1, 254)), 8'd1,
                         8'($urandom_range(1, 254)), 8'd254};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (directed_rows[r])
            drive_item(directed_rows[r].op, directed_rows[r].x, directed_rows[r].y,
                       directed_rows[r].v, directed_rows[r].typed, directed_rows[r].result);

        // Random lines under a series of thresholds, extremes included.
        for (p = 0; p < 6; p++)
        begin
            wait_idle();
            write_threshold(phase_levels[p]);
            phase_start = items_sent;
            // Overfill the store while the receiver holds off for a long stretch.
            if (p == 2)
                run_line(DENSE_LEN, 1'b1, 1'b1);
            while (items_sent - phase_start < PHASE_ITEMS)
                run_line(pick_length(), 1'b0, 1'b0);
        end

        wait_idle();
        if (mismatch_count == 0 && expected_strokes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
